@@ hw/rtl/rtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc_pkg
// Types and codes shared by the range translation cache and its table.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam logic [ADDR_W-1:0] RESET_DEFAULT_LENGTH = 32'd4096;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } rtc_op_t;

    typedef struct packed {
        rtc_op_t           op;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] phys_base;
        logic [ADDR_W-1:0] range_length;
    } rtc_req_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] phys_addr;
        logic              dropped;
    } rtc_rsp_t;

    // One table slot
    typedef struct packed {
        logic [ADDR_W-1:0] virt_base;
        logic [ADDR_W-1:0] phys_base;
        logic [ADDR_W-1:0] length;
    } rtc_entry_t;

endpackage

@@ hw/rtl/rtc_table.sv @@
// ----------------------------------------------------------------------------
// rtc_table
// Range table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtc_table #(
    parameter int unsigned ENTRIES = 8,
    parameter int unsigned IDX_W   = 3
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  rtc_pkg::rtc_entry_t wr_entry,
    input  logic [IDX_W-1:0]    rd_addr,
    output rtc_pkg::rtc_entry_t rd_entry
);
    import rtc_pkg::*;

    rtc_entry_t mem [ENTRIES];
    rtc_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

@@ hw/rtl/range_translation_cache.sv @@
// ----------------------------------------------------------------------------
// range_translation_cache
// Fully associative table of virtual-to-physical ranges, filled in order,
// searched lowest slot first by one shared subtract/compare/add unit.
// ----------------------------------------------------------------------------
//  channel | signals                     | direction | payload
//  --------+-----------------------------+-----------+------------------------
//  req     | req_valid, req_ready, req   | in        | op, virt_addr,
//          |                             |           | phys_base, range_length
//  rsp     | rsp_valid, rsp_ready, rsp   | out       | hit, phys_addr, dropped
//  cfg     | cfg_valid, cfg_ready, cfg_data | in     | default_length
//
// Insert and clear: the sequencer goes from idle straight to its done state.
// Lookup: slots compared are 0 on an empty table, else 1 up to the fill
// count, stopping at the first hit; one slot per cycle through the table
// read port and compare unit.
// Reset empties the table (fill count to zero) and restores default_length.
// A result waiting on rsp holds the sequencer in its done state; requests
// are taken again once the result moves to the output register.
// ----------------------------------------------------------------------------
module range_translation_cache #(
    parameter int unsigned ENTRIES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rtc_pkg::rtc_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rtc_pkg::rtc_rsp_t rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import rtc_pkg::*;

    localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned FILL_W = $clog2(ENTRIES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0] dlen_reg;
    logic [ADDR_W-1:0] va_reg, va_next;
    rtc_rsp_t          res_reg, res_next;
    rtc_rsp_t          rsp_reg;
    logic              rsp_valid_reg;

    logic              req_fire;
    logic              wr_en;
    rtc_entry_t        wr_entry;
    logic [IDX_W-1:0]  rd_addr;
    rtc_entry_t        rd_entry;

    logic [ADDR_W:0]   diff;
    logic [ADDR_W-1:0] offset;
    logic              match;
    logic              last_slot;
    logic              rsp_load;

    rtc_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (fill_reg[IDX_W-1:0]),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign wr_en = req_fire && (req.op == OP_INSERT) && (fill_reg < FILL_MAX);
    assign wr_entry.virt_base = req.virt_addr;
    assign wr_entry.phys_base = req.phys_base;
    assign wr_entry.length    = (req.range_length != '0) ? req.range_length : dlen_reg;

    // Shared compare unit: borrow of va - base rejects addresses below the base.
    assign diff      = {1'b0, va_reg} - {1'b0, rd_entry.virt_base};
    assign offset    = diff[ADDR_W-1:0];
    assign match     = !diff[ADDR_W] && (offset < rd_entry.length);
    assign last_slot = ((FILL_W'(scan_idx_reg) + FILL_W'(1)) == fill_reg);

    // Read the slot that will be compared in the next cycle
    assign rd_addr = (state_reg == S_CMP) ? scan_idx_reg + IDX_W'(1) : '0;

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        scan_idx_next = scan_idx_reg;
        va_next       = va_reg;
        res_next      = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    va_next       = req.virt_addr;
                    scan_idx_next = '0;
                    res_next      = '0;
                    state_next    = S_DONE;
                    case (req.op)
                        OP_LOOKUP:
                        begin
                            if (fill_reg != '0)
                            begin
                                state_next = S_CMP;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (fill_reg < FILL_MAX)
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            else
                            begin
                                res_next.dropped = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                if (match)
                begin
                    res_next.hit       = 1'b1;
                    res_next.phys_addr = rd_entry.phys_base + offset;
                    state_next         = S_DONE;
                end
                else if (last_slot)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            dlen_reg      <= RESET_DEFAULT_LENGTH;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_valid && cfg_ready)
            begin
                dlen_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        va_reg       <= va_next;
        res_reg      <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count above table size");

    a_insert_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.op == OP_INSERT && fill_reg < FILL_MAX)
        |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("insert did not advance fill count");

    a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && match) |=> (state_reg == S_DONE && res_reg.hit))
        else $error("scan did not stop on first hit");

    a_hit_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.dropped))
        else $error("result flags both hit and dropped");

endmodule
